### hdl/assert_macros.svh
// Assertion macros shared by the spectrum column block.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
	else $error("assertion failed: condition must not hold");

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
	else $error("assertion failed: implication broken");

`endif

### hdl/sbcm_pkg.sv
// Shared constants and types of the spectrum bin to column max-hold block.
// Used by the divider and the top level; depends on nothing.
package sbcm_pkg;

	localparam int COLUMNS  = 240;
	localparam int COL_W    = $clog2(COLUMNS);
	localparam int HZ_W     = 33;
	localparam int ACC_W    = HZ_W + 1;
	localparam int FREQ_W   = HZ_W + 2;
	localparam int PROD_W   = ACC_W + COL_W;
	localparam int DIV_CNT_W = $clog2(PROD_W);
	localparam int BIN_W    = 8;
	localparam int PWR_W    = 8;
	localparam int OP_W     = 2;
	localparam int IDX_W    = 2;

	localparam logic [FREQ_W-1:0] BIN_HZ = FREQ_W'(78125);

	localparam logic [BIN_W-1:0] UPPER_FIRST = BIN_W'(2);
	localparam logic [BIN_W-1:0] UPPER_LAST  = BIN_W'(119);
	localparam logic [BIN_W-1:0] LOWER_FIRST = BIN_W'(136);
	localparam logic [BIN_W-1:0] LOWER_LAST  = BIN_W'(253);
	localparam logic [FREQ_W-1:0] UPPER_BIAS_HZ = FREQ_W'(126 * 78125);
	localparam logic [FREQ_W-1:0] LOWER_BIAS_HZ = FREQ_W'(120 * 78125);
	// A run underflows when the centre lies below (bias - first) bins.
	localparam logic [FREQ_W-1:0] UPPER_LIMIT_HZ = FREQ_W'((126 - 2) * 78125);
	// The lower run's first bin lies above its bias, so it can never underflow.
	localparam logic [FREQ_W-1:0] LOWER_LIMIT_HZ = '0;

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	localparam logic [OP_W-1:0] OP_BIN   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [IDX_W-1:0] REG_PIXEL_STEP = 2'd0;
	localparam logic [IDX_W-1:0] REG_BIN_CREDIT = 2'd1;
	localparam logic [IDX_W-1:0] REG_SPAN_LOW   = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPAN_HIGH  = 2'd3;

	typedef struct packed {
		logic              done;
		logic              busy;
		logic [PROD_W-1:0] quotient;
		logic [ACC_W-1:0]  remainder;
	} div_res_t;

endpackage

### hdl/sbcm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; holds the column line of the spectrum block.
module sbcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 240
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/sbcm_div.sv
// Restoring divider, one quotient bit per cycle, shared by the progress and
// column calculations. Depends on sbcm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sbcm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sbcm_pkg::PROD_W-1:0] dividend,
	input  logic [sbcm_pkg::ACC_W-1:0]  divisor,
	output sbcm_pkg::div_res_t          res
);

	logic                          busy_q;
	logic                          done_q;
	logic [sbcm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [sbcm_pkg::PROD_W-1:0]    quo_q;
	logic [sbcm_pkg::ACC_W-1:0]     rem_q;
	logic [sbcm_pkg::ACC_W-1:0]     dvs_q;
	logic [sbcm_pkg::ACC_W:0]       shifted;
	logic [sbcm_pkg::ACC_W+1:0]     trial;
	logic                          ge;

	assign shifted = {rem_q, quo_q[sbcm_pkg::PROD_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge      = !trial[sbcm_pkg::ACC_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= sbcm_pkg::DIV_CNT_W'(sbcm_pkg::PROD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - sbcm_pkg::DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[sbcm_pkg::ACC_W-1:0] : shifted[sbcm_pkg::ACC_W-1:0];
			quo_q <= {quo_q[sbcm_pkg::PROD_W-2:0], ge};
		end
	end

	assign res.done      = done_q;
	assign res.busy      = busy_q;
	assign res.quotient  = quo_q;
	assign res.remainder = rem_q;

	`ASSERT_NEVER(a_start_idle, clk, arst_n, start && busy_q)
	`ASSERT_IMPL(a_done_after_busy, clk, arst_n, done_q, !busy_q && $past(busy_q))

endmodule

### hdl/spectrum_bin_to_column_max_hold.sv
// Spectrum bin to display column max-hold, top level with control sequencer.
// A bin item takes two passes of the shared divider (progress steps, then column index)
// plus sequencing and the line RAM update; it is quicker when it stops early or progress
// is full. A read passes through ST_RD, a clear or ignored item goes straight to ST_OUT;
// the next item can be taken in the same cycle as its result appears on m_tvalid.
// Reset (asynchronous, active low) zeroes config registers, progress, credit and column valid bits.
`include "assert_macros.svh"
module spectrum_bin_to_column_max_hold (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // bin_number, power, center_hz, column, zero pad
	input  logic [1:0]  s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // progress, column_value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [32:0] cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ACC  = 4'd1;
	localparam logic [3:0] ST_DIV1 = 4'd2;
	localparam logic [3:0] ST_FREQ = 4'd3;
	localparam logic [3:0] ST_SPAN = 4'd4;
	localparam logic [3:0] ST_MUL  = 4'd5;
	localparam logic [3:0] ST_GO2  = 4'd6;
	localparam logic [3:0] ST_DIV2 = 4'd7;
	localparam logic [3:0] ST_CMP  = 4'd8;
	localparam logic [3:0] ST_RD   = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;

	localparam int CW = sbcm_pkg::COL_W;
	localparam int FW = sbcm_pkg::FREQ_W;
	localparam int AW = sbcm_pkg::ACC_W;
	localparam int PW = sbcm_pkg::PROD_W;
	localparam int HW = sbcm_pkg::HZ_W;

	logic [3:0]  state_q;
	logic [HW-1:0] pixel_q, credit_cfg_q, low_q, high_q;
	logic [AW-1:0] credit_q;
	logic [CW-1:0] progress_q;
	logic [sbcm_pkg::COLUMNS-1:0] valid_q;

	logic [sbcm_pkg::BIN_W-1:0] bin_q;
	logic [sbcm_pkg::PWR_W-1:0] power_q;
	logic [HW-1:0] center_q;
	logic          upper_q;
	logic [FW-1:0] freq_q;
	logic [PW-1:0] prod_q;
	logic [CW-1:0] col_q;
	logic [sbcm_pkg::PWR_W-1:0] value_q;
	logic [15:0]   out_data_q;
	logic          out_valid_q;
	logic          out_load;

	logic [sbcm_pkg::BIN_W-1:0] in_bin;
	logic [sbcm_pkg::PWR_W-1:0] in_power;
	logic [HW-1:0] in_center;
	logic [CW-1:0] in_column;
	logic          in_upper, in_lower, cfg_ok, accept;

	logic [AW:0]   acc_sum;
	logic [AW-1:0] acc_sat;
	logic [CW-1:0] room;
	logic [PW-1:0] room_prod;
	logic [FW-1:0] freq_sum, limit, bias_hz, diff;
	logic          div_start;
	logic [PW-1:0] div_dividend;
	logic [AW-1:0] div_divisor;
	sbcm_pkg::div_res_t div_res;

	logic          ram_we;
	logic [CW-1:0] ram_raddr;
	logic [sbcm_pkg::PWR_W-1:0] ram_rdata, stored;

	assign in_bin    = s_tdata[7:0];
	assign in_power  = s_tdata[15:8];
	assign in_center = s_tdata[48:16];
	assign in_column = s_tdata[56:49];
	assign in_upper  = (in_bin >= sbcm_pkg::UPPER_FIRST) && (in_bin <= sbcm_pkg::UPPER_LAST);
	assign in_lower  = (in_bin >= sbcm_pkg::LOWER_FIRST) && (in_bin <= sbcm_pkg::LOWER_LAST);
	assign cfg_ok    = (pixel_q != '0) && (credit_cfg_q != '0) && (high_q > low_q);

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	assign acc_sum   = {1'b0, credit_q} + (AW + 1)'(credit_cfg_q);
	assign acc_sat   = acc_sum[AW] ? sbcm_pkg::ACC_MAX : acc_sum[AW-1:0];
	assign room      = CW'(sbcm_pkg::COLUMNS) - progress_q;
	assign room_prod = PW'(room) * PW'(pixel_q);

	assign bias_hz  = upper_q ? sbcm_pkg::UPPER_BIAS_HZ : sbcm_pkg::LOWER_BIAS_HZ;
	assign limit    = upper_q ? sbcm_pkg::UPPER_LIMIT_HZ : sbcm_pkg::LOWER_LIMIT_HZ;
	assign freq_sum = FW'(center_q) + FW'(bin_q) * sbcm_pkg::BIN_HZ - bias_hz;
	assign diff     = freq_q - FW'(low_q);

	// The divider computes credit / step first, then column product / span.
	assign div_start    = ((state_q == ST_ACC) && (progress_q < CW'(sbcm_pkg::COLUMNS)))
		|| (state_q == ST_GO2);
	assign div_dividend = (state_q == ST_ACC) ? PW'(acc_sat) : prod_q;
	assign div_divisor  = (state_q == ST_ACC) ? AW'(pixel_q) : AW'(high_q - low_q);

	sbcm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.res      (div_res)
	);

	assign ram_raddr = (state_q == ST_IDLE) ? in_column : div_res.quotient[CW-1:0];
	assign stored    = valid_q[col_q] ? ram_rdata : '0;
	assign ram_we    = (state_q == ST_CMP) && (power_q > stored);

	sbcm_ram #(
		.WIDTH (sbcm_pkg::PWR_W),
		.DEPTH (sbcm_pkg::COLUMNS)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_q),
		.wdata (power_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_q      <= '0;
			credit_cfg_q <= '0;
			low_q        <= '0;
			high_q       <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				sbcm_pkg::REG_PIXEL_STEP: pixel_q      <= cfg_data;
				sbcm_pkg::REG_BIN_CREDIT: credit_cfg_q <= cfg_data;
				sbcm_pkg::REG_SPAN_LOW:   low_q        <= cfg_data;
				sbcm_pkg::REG_SPAN_HIGH:  high_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			credit_q    <= '0;
			progress_q  <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_OUT;
						case (s_tuser)
							sbcm_pkg::OP_BIN: begin
								if (cfg_ok && (in_upper || in_lower)) begin
									state_q <= ST_ACC;
								end
							end
							sbcm_pkg::OP_READ: begin
								if (in_column < CW'(sbcm_pkg::COLUMNS)) begin
									state_q <= ST_RD;
								end
							end
							sbcm_pkg::OP_CLEAR: begin
								valid_q    <= '0;
								progress_q <= '0;
								credit_q   <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_ACC: begin
					credit_q <= acc_sat;
					state_q  <= (progress_q < CW'(sbcm_pkg::COLUMNS)) ? ST_DIV1 : ST_FREQ;
				end
				ST_DIV1: begin
					if (div_res.done) begin
						state_q <= ST_FREQ;
						if (div_res.quotient > PW'(room)) begin
							progress_q <= CW'(sbcm_pkg::COLUMNS);
							credit_q   <= credit_q - room_prod[AW-1:0];
						end else begin
							progress_q <= progress_q + div_res.quotient[CW-1:0];
							credit_q   <= div_res.remainder;
						end
					end
				end
				ST_FREQ: begin
					state_q <= (FW'(center_q) < limit) ? ST_OUT : ST_SPAN;
				end
				ST_SPAN: begin
					state_q <= (freq_q < FW'(low_q)) ? ST_OUT : ST_MUL;
				end
				ST_MUL: state_q <= ST_GO2;
				ST_GO2: state_q <= ST_DIV2;
				ST_DIV2: begin
					if (div_res.done) begin
						state_q <= (div_res.quotient < PW'(sbcm_pkg::COLUMNS)) ? ST_CMP : ST_OUT;
					end
				end
				ST_CMP: begin
					if (ram_we) begin
						valid_q[col_q] <= 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_RD: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q    <= in_bin;
			power_q  <= in_power;
			center_q <= in_center;
			upper_q  <= in_upper;
			col_q    <= in_column;
			value_q  <= '0;
		end
		if (state_q == ST_FREQ) begin
			freq_q <= freq_sum;
		end
		if (state_q == ST_MUL) begin
			prod_q <= PW'(diff) * PW'(sbcm_pkg::COLUMNS);
		end
		if ((state_q == ST_DIV2) && div_res.done) begin
			col_q <= div_res.quotient[CW-1:0];
		end
		if (state_q == ST_RD) begin
			value_q <= stored;
		end
		if (out_load) begin
			out_data_q <= {value_q, progress_q};
		end
	end

	`ASSERT_NEVER(a_progress_cap, clk, arst_n, progress_q > CW'(sbcm_pkg::COLUMNS))
	`ASSERT_IMPL(a_write_in_cmp, clk, arst_n, ram_we, state_q == ST_CMP)
	`ASSERT_IMPL(a_div_done_waited, clk, arst_n, div_res.done, state_q == ST_DIV1 || state_q == ST_DIV2)

endmodule
